### hw/rtl/wmmb_pkg.sv
// Shared types, constants and codes of the min/max bucketing block.
package wmmb_pkg;

    // Channel store geometry
    localparam int MAX_CHANNELS = 8;
    localparam int IDX_W        = $clog2(MAX_CHANNELS);
    localparam int TRK_W        = $clog2(MAX_CHANNELS + 1);

    // Field widths
    localparam int CHAN_W   = 3;
    localparam int SAMPLE_W = 16;
    localparam int COUNT_W  = 24;
    localparam int CC_W     = 4;

    // Stream payload widths (zero filled up to whole bytes)
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 40;

    // Register file
    localparam int             APB_ADDR_W = 3;
    localparam int             APB_DATA_W = 32;
    localparam logic           REG_CHANNEL_COUNT      = 1'b0;
    localparam logic           REG_SAMPLES_PER_BUCKET = 1'b1;
    localparam logic [CC_W-1:0]    CC_RESET  = CC_W'(2);
    localparam logic [COUNT_W-1:0] SPB_RESET = COUNT_W'(256);

    // Request kinds carried in tuser
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_FLUSH  = 1'b1;

    // One store entry: running extremes of a channel
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] hi;
        logic signed [SAMPLE_W-1:0] lo;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPD,
        ST_EMIT_RD,
        ST_EMIT_WR
    } t_state;

endpackage

### hw/rtl/wmmb_ram.sv
// Generic single write port, single read port RAM with registered read data.
module wmmb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/waveform_min_max_bucketing_top.sv
// Top level of the min/max peak bucketing block for interleaved audio.
//
//  Channel     | Dir | Handshake             | Contents
//  ------------+-----+-----------------------+-----------------------------------------
//  s_axis      | in  | tvalid/tready         | one channel sample or a flush request
//  m_axis      | out | tvalid/tready         | one min/max result per tracked channel
//  apb         | in  | psel/penable/pready   | channel_count (0x0), samples_per_bucket (0x4)
//
//  A sample is handled as accept plus read of its store entry, then the
//  read-modify-write of that entry in the store RAM.
//  A bucket end emits one result per tracked channel (RAM read, then load
//  of the output register); m_axis back-pressure stalls the load.
//  The input is not taken while a sample update or an emission is under way.
//  Reset clears the per-entry valid bits at once; no clearing pass.
module waveform_min_max_bucketing_top
    import wmmb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_DATA_W-1:0]   s_axis_tdata,   // [2:0] chan, [18:3] sample_value
    input  logic                  s_axis_tuser,   // [0] req_type
    input  logic                  s_axis_tlast,   // frame_end
    // Output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_DATA_W-1:0]   m_axis_tdata,   // [2:0] out_chan, [18:3] bucket_min,
                                                  // [34:19] bucket_max
    output logic                  m_axis_tlast,   // last
    // Configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // Configuration registers
    logic [CC_W-1:0]    r_chan_cnt;
    logic [COUNT_W-1:0] r_spb;
    logic               w_cfg_wr;

    // Sequencer and captured item
    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_chan;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic               r_fend;
    logic               r_hit;
    logic [IDX_W-1:0]   r_k;

    // Bucket state
    logic [COUNT_W-1:0]      r_count;
    logic [MAX_CHANNELS-1:0] r_valid;

    // Output register
    logic               r_m_valid;
    logic [M_DATA_W-1:0] r_m_data;
    logic               r_m_last;

    // Datapath signals
    logic [TRK_W-1:0]   w_tracked;
    logic               w_s_acc;
    logic [IDX_W-1:0]   w_in_chan;
    logic               w_in_hit;
    logic               w_flush_go;
    logic [COUNT_W-1:0] w_cnt_inc;
    logic               w_bucket_end;
    logic               w_emit_go;
    logic               w_slot_free;
    logic               w_k_last;
    logic               w_load;
    logic               w_clear;
    logic               w_mem_we;
    logic               w_mem_re;
    logic [IDX_W-1:0]   w_mem_raddr;
    logic [ENTRY_W-1:0] w_mem_rdata;
    t_entry             w_cur;
    t_entry             w_new;
    t_entry             w_emit_entry;

    // Configuration port: write in access phase, read back combinationally
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_cnt <= CC_RESET;
            r_spb      <= SPB_RESET;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                REG_CHANNEL_COUNT:      r_chan_cnt <= pwdata[CC_W-1:0];
                REG_SAMPLES_PER_BUCKET: r_spb      <= pwdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_CHANNEL_COUNT:      prdata = APB_DATA_W'(r_chan_cnt);
            REG_SAMPLES_PER_BUCKET: prdata = APB_DATA_W'(r_spb);
            default:                prdata = '0;
        endcase
    end

    // Tracked channel count, saturated at the store depth
    assign w_tracked = (TRK_W'(r_chan_cnt) > TRK_W'(MAX_CHANNELS)) ?
                       TRK_W'(MAX_CHANNELS) : TRK_W'(r_chan_cnt);

    // Input decode
    assign w_s_acc    = s_axis_tvalid && s_axis_tready;
    assign w_in_chan  = IDX_W'(s_axis_tdata[CHAN_W-1:0]);
    assign w_in_hit   = TRK_W'(s_axis_tdata[CHAN_W-1:0]) < w_tracked;
    assign w_flush_go = w_s_acc && (s_axis_tuser == REQ_FLUSH) && (r_count != '0);

    // Frame count advance and bucket end test
    assign w_cnt_inc    = r_count + COUNT_W'(1);
    assign w_bucket_end = (r_state == ST_UPD) && r_fend && (w_cnt_inc >= r_spb);
    assign w_emit_go    = w_flush_go || w_bucket_end;

    // Emission progress
    assign w_slot_free = !r_m_valid || m_axis_tready;
    assign w_k_last    = (TRK_W'(r_k) + TRK_W'(1)) == w_tracked;
    assign w_load      = (r_state == ST_EMIT_WR) && w_slot_free;
    assign w_clear     = (w_emit_go && (w_tracked == '0)) || (w_load && w_k_last);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_flush_go) begin
                    n_state = (w_tracked == '0) ? ST_IDLE : ST_EMIT_RD;
                end else if (w_s_acc && (s_axis_tuser == REQ_SAMPLE)) begin
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                if (w_bucket_end && (w_tracked != '0)) begin
                    n_state = ST_EMIT_RD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT_RD: begin
                n_state = ST_EMIT_WR;
            end
            ST_EMIT_WR: begin
                if (w_load) begin
                    n_state = w_k_last ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control outputs of the sequencer
    always_comb begin
        s_axis_tready = 1'b0;
        w_mem_re      = 1'b0;
        w_mem_raddr   = r_k;
        w_mem_we      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                w_mem_re      = w_s_acc && (s_axis_tuser == REQ_SAMPLE) && w_in_hit;
                w_mem_raddr   = w_in_chan;
            end
            ST_UPD: begin
                w_mem_we = r_hit;
            end
            ST_EMIT_RD: begin
                w_mem_re = 1'b1;
            end
            ST_EMIT_WR: ;
            default: ;
        endcase
    end

    // Channel store
    wmmb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_CHANNELS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (r_chan),
        .i_wdata (w_new),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    // Fold the sample into its entry; an entry never written reads as zero
    always_comb begin
        w_cur = r_valid[r_chan] ? t_entry'(w_mem_rdata) : '0;
        if (r_count == '0) begin
            w_new.lo = r_sample;
            w_new.hi = r_sample;
        end else begin
            w_new.lo = (r_sample < w_cur.lo) ? r_sample : w_cur.lo;
            w_new.hi = (r_sample > w_cur.hi) ? r_sample : w_cur.hi;
        end
    end

    assign w_emit_entry = r_valid[r_k] ? t_entry'(w_mem_rdata) : '0;

    // Sequencer, captured item and bucket state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_valid <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            if (w_clear) begin
                r_valid <= '0;
                r_count <= '0;
            end else begin
                if (w_mem_we) begin
                    r_valid[r_chan] <= 1'b1;
                end
                if ((r_state == ST_UPD) && r_fend) begin
                    r_count <= w_cnt_inc;
                end
            end
            if (w_emit_go) begin
                r_k <= '0;
            end else if (w_load) begin
                r_k <= r_k + IDX_W'(1);
            end
        end
    end

    // Hold the accepted sample
    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_chan   <= w_in_chan;
            r_sample <= s_axis_tdata[CHAN_W +: SAMPLE_W];
            r_fend   <= s_axis_tlast && (s_axis_tuser == REQ_SAMPLE);
            r_hit    <= w_in_hit;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_m_data <= {5'b0, w_emit_entry.hi, w_emit_entry.lo, CHAN_W'(r_k)};
            r_m_last <= w_k_last;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tlast  = r_m_last;

    // Checks
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_acc && (s_axis_tuser == REQ_SAMPLE)) |=> !s_axis_tready)
        else $error("input accepted while previous item still in progress");

    a_emit_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT_RD || r_state == ST_EMIT_WR) |-> (TRK_W'(r_k) < w_tracked))
        else $error("emission index beyond tracked channels");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_k_last) |=> (r_valid == '0 && r_count == '0 && m_axis_tlast))
        else $error("store not cleared after final result of a bucket");

endmodule

### bench/wmmb_bucket_checker.sv
// Watches the stream and APB ports, predicts each min/max bucket and compares it.
module wmmb_bucket_checker
    import wmmb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input stream
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [S_DATA_W-1:0]   i_s_tdata,    // [2:0] chan, [18:3] sample_value
    input  logic                  i_s_tuser,    // [0] req_type
    input  logic                  i_s_tlast,    // frame_end
    // Output stream
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [M_DATA_W-1:0]   i_m_tdata,    // [2:0] out_chan, [18:3] bucket_min,
                                                // [34:19] bucket_max
    input  logic                  i_m_tlast,    // last
    // Configuration bus
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    input  logic [APB_DATA_W-1:0] i_prdata,
    input  logic                  i_pready,
    // Status towards the stimulus side
    output int                    o_pending,
    output int                    o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [CHAN_W-1:0]          chan;
        logic signed [SAMPLE_W-1:0] lo;
        logic signed [SAMPLE_W-1:0] hi;
        logic                       last;
    } t_bucket;

    // Buckets predicted but not yet seen on the output stream
    t_bucket bucket_q[$];

    // Shadow of the register file and of the channel store
    logic [CC_W-1:0]            chan_count_sh;
    logic [COUNT_W-1:0]         bucket_size_sh;
    logic signed [SAMPLE_W-1:0] lo_store [MAX_CHANNELS];
    logic signed [SAMPLE_W-1:0] hi_store [MAX_CHANNELS];
    logic [COUNT_W-1:0]         frames_seen;

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        o_fail_count++;
    endtask

    function automatic int tracked_count();
        return (int'(chan_count_sh) > MAX_CHANNELS) ? MAX_CHANNELS : int'(chan_count_sh);
    endfunction

    task automatic clear_store();
        int k;
        for (k = 0; k < MAX_CHANNELS; k++) begin
            lo_store[k] = '0;
            hi_store[k] = '0;
        end
        frames_seen = '0;
    endtask

    // Queue one result per tracked channel, then clear the store
    task automatic emit_bucket();
        int      n;
        int      k;
        t_bucket r;
        n = tracked_count();
        for (k = 0; k < n; k++) begin
            r.chan = CHAN_W'(k);
            r.lo   = lo_store[k];
            r.hi   = hi_store[k];
            r.last = (k == n - 1);
            bucket_q.push_back(r);
        end
        clear_store();
    endtask

    // Fold one accepted request into the store
    task automatic fold_request(input logic req, input logic [CHAN_W-1:0] chan,
                                input logic signed [SAMPLE_W-1:0] value, input logic fend);
        if (req == REQ_FLUSH) begin
            if (frames_seen != '0) begin
                emit_bucket();
            end
        end else begin
            if (int'(chan) < tracked_count()) begin
                if (frames_seen == '0) begin
                    lo_store[chan] = value;
                    hi_store[chan] = value;
                end else begin
                    if (value < lo_store[chan]) begin
                        lo_store[chan] = value;
                    end
                    if (value > hi_store[chan]) begin
                        hi_store[chan] = value;
                    end
                end
            end
            if (fend) begin
                frames_seen = frames_seen + 1'b1;
                if (frames_seen >= bucket_size_sh) begin
                    emit_bucket();
                end
            end
        end
    endtask

    // Compare one result transaction with the oldest prediction
    task automatic compare_result();
        t_bucket                    want;
        logic [CHAN_W-1:0]          got_chan;
        logic signed [SAMPLE_W-1:0] got_lo;
        logic signed [SAMPLE_W-1:0] got_hi;
        got_chan = i_m_tdata[CHAN_W-1:0];
        got_lo   = i_m_tdata[CHAN_W +: SAMPLE_W];
        got_hi   = i_m_tdata[CHAN_W + SAMPLE_W +: SAMPLE_W];
        if (bucket_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result chan %0d min %0d max %0d",
                                      got_chan, got_lo, got_hi));
            return;
        end
        want = bucket_q.pop_front();
        if (got_chan !== want.chan) begin
            report_mismatch($sformatf("out_chan %0d, expected %0d", got_chan, want.chan));
        end
        if (got_lo !== want.lo) begin
            report_mismatch($sformatf("chan %0d bucket_min %0d, expected %0d",
                                      want.chan, got_lo, want.lo));
        end
        if (got_hi !== want.hi) begin
            report_mismatch($sformatf("chan %0d bucket_max %0d, expected %0d",
                                      want.chan, got_hi, want.hi));
        end
        if (i_m_tlast !== want.last) begin
            report_mismatch($sformatf("chan %0d last %b, expected %b",
                                      want.chan, i_m_tlast, want.last));
        end
    endtask

    // Check read data against the shadow registers
    task automatic check_readback();
        logic [APB_DATA_W-1:0] want;
        if (i_paddr[APB_ADDR_W-1:2] == REG_SAMPLES_PER_BUCKET) begin
            want = APB_DATA_W'(bucket_size_sh);
        end else begin
            want = APB_DATA_W'(chan_count_sh);
        end
        if (i_prdata !== want) begin
            report_mismatch($sformatf("register 0x%0h reads 0x%0h, expected 0x%0h",
                                      i_paddr, i_prdata, want));
        end
    endtask

    // Track every handshake at the clock edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            chan_count_sh  = CC_RESET;
            bucket_size_sh = SPB_RESET;
            clear_store();
            bucket_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                compare_result();
            end
            if (i_s_tvalid && i_s_tready) begin
                fold_request(i_s_tuser, i_s_tdata[CHAN_W-1:0],
                             i_s_tdata[CHAN_W +: SAMPLE_W], i_s_tlast);
            end
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    case (i_paddr[APB_ADDR_W-1:2])
                        REG_CHANNEL_COUNT: begin
                            chan_count_sh = i_pwdata[CC_W-1:0];
                        end
                        REG_SAMPLES_PER_BUCKET: begin
                            bucket_size_sh = i_pwdata[COUNT_W-1:0];
                        end
                        default: begin
                        end
                    endcase
                end else begin
                    check_readback();
                end
            end
        end
        o_pending = bucket_q.size();
    end

endmodule

### bench/testbench.sv
// Stimulus, clock, reset and verdict for the min/max bucketing block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import wmmb_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 4;
    localparam int LIMIT_CYCLES    = 600000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 10;
    localparam int DRAIN_CYCLES    = 40;
    localparam int RANDOM_ITEMS    = 220;
    localparam int PHASE_ITEMS     = 30;

    localparam logic [APB_ADDR_W-1:0] ADDR_CC  = {REG_CHANNEL_COUNT, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_SPB = {REG_SAMPLES_PER_BUCKET, 2'b00};

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  s_axis_tlast  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [APB_ADDR_W-1:0] paddr         = '0;
    logic [APB_DATA_W-1:0] pwdata        = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int pending;
    int fail_count;
    int cycle_count   = 0;
    int items_sent    = 0;
    int cur_channels  = int'(CC_RESET);
    int hold_off_req  = 0;
    bit quiet_tail    = 1'b0;

    waveform_min_max_bucketing_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    wmmb_bucket_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_s_tlast    (s_axis_tlast),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tlast    (m_axis_tlast),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // Free-running clock
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Abort a run that hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: random back-pressure, one long hold-off on request
    initial begin
        int hold_off_done;
        hold_off_done = 0;
        forever begin
            if (hold_off_req != hold_off_done) begin
                hold_off_done++;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    end

    // One APB transaction, with the bus left idle afterwards
    task automatic apb_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Write both registers with junk in the unused bits, then read them back
    task automatic set_config(input logic [CC_W-1:0] cc, input logic [COUNT_W-1:0] spb);
        logic [APB_DATA_W-1:0] junk;
        junk = $urandom();
        apb_access(1'b1, ADDR_CC, {junk[APB_DATA_W-1:CC_W], cc});
        junk = $urandom();
        apb_access(1'b1, ADDR_SPB, {junk[APB_DATA_W-1:COUNT_W], spb});
        apb_access(1'b0, ADDR_CC, '0);
        apb_access(1'b0, ADDR_SPB, '0);
        cur_channels = int'(cc);
    endtask

    // Offer one item and hold it until the block takes it
    task automatic push_item(input logic req, input logic [CHAN_W-1:0] chan,
                             input logic [SAMPLE_W-1:0] value, input logic fend);
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= S_DATA_W'({value, chan});
        s_axis_tuser  <= req;
        s_axis_tlast  <= fend;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    // Drop valid and wait until every predicted result has come out
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    // One frame over the tracked channels, now and then with a gap or a stray channel
    task automatic send_frame();
        int n;
        int ch;
        if (cur_channels == 0) begin
            n = $urandom_range(1, 3);
        end else if (cur_channels > MAX_CHANNELS) begin
            n = MAX_CHANNELS;
        end else begin
            n = cur_channels;
        end
        for (ch = 0; ch < n; ch++) begin
            if (ch == n - 1 && n < MAX_CHANNELS && $urandom_range(0, 4) == 0) begin
                push_item(REQ_SAMPLE, CHAN_W'($urandom_range(n, MAX_CHANNELS - 1)),
                          pick_sample(), 1'b0);
            end
            if (ch != n - 1 && $urandom_range(0, 9) == 0) begin
                continue;
            end
            push_item(REQ_SAMPLE, CHAN_W'(ch), pick_sample(), ch == n - 1);
        end
    endtask

    // Mostly well-formed frames, with flushes and random noise mixed in
    task automatic run_traffic(input int count);
        int start;
        start = items_sent;
        while (items_sent - start < count) begin
            case ($urandom_range(0, 15))
                0:       push_item(REQ_FLUSH, CHAN_W'($urandom()), SAMPLE_W'($urandom()),
                                   1'($urandom()));
                1:       push_item(1'($urandom()), CHAN_W'($urandom()),
                                   SAMPLE_W'($urandom()), 1'($urandom()));
                default: send_frame();
            endcase
        end
        if ($urandom_range(0, 1) == 0) begin
            push_item(REQ_FLUSH, CHAN_W'($urandom()), SAMPLE_W'($urandom()), 1'($urandom()));
        end
    endtask

    task automatic pick_config();
        logic [CC_W-1:0]    cc;
        logic [COUNT_W-1:0] spb;
        case ($urandom_range(0, 9))
            0:       cc = '0;
            1:       cc = CC_W'($urandom_range(MAX_CHANNELS + 1, 15));
            2:       cc = CC_W'(MAX_CHANNELS);
            default: cc = CC_W'($urandom_range(1, MAX_CHANNELS));
        endcase
        case ($urandom_range(0, 9))
            0:       spb = '0;
            1:       spb = '1;
            2:       spb = COUNT_W'($urandom_range(5, 12));
            default: spb = COUNT_W'($urandom_range(1, 4));
        endcase
        set_config(cc, spb);
    endtask

    // Main stimulus
    initial begin
        int first_random;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values of the registers
        apb_access(1'b0, ADDR_CC, '0);
        apb_access(1'b0, ADDR_SPB, '0);

        // Three channels, two frames per bucket
        set_config(4'd3, 24'd2);
        // Flush with nothing pending
        push_item(REQ_FLUSH, 3'd5, 16'h1234, 1'b1);
        // Full-scale extremes, first frame loads the store
        push_item(REQ_SAMPLE, 3'd0, 16'h8000, 1'b0);
        push_item(REQ_SAMPLE, 3'd1, 16'h7FFF, 1'b0);
        push_item(REQ_SAMPLE, 3'd2, 16'h0000, 1'b1);
        // Second frame folds in, closed by an untracked channel
        push_item(REQ_SAMPLE, 3'd0, 16'h7FFF, 1'b0);
        push_item(REQ_SAMPLE, 3'd1, 16'h8000, 1'b0);
        push_item(REQ_SAMPLE, 3'd7, 16'h5555, 1'b1);
        // Channel two missing from the bucket
        push_item(REQ_SAMPLE, 3'd0, 16'hFFFF, 1'b1);
        push_item(REQ_SAMPLE, 3'd1, 16'h0001, 1'b1);
        // Partial bucket with an unfinished frame, then flush
        push_item(REQ_SAMPLE, 3'd2, 16'hAAAA, 1'b1);
        push_item(REQ_SAMPLE, 3'd1, 16'h4000, 1'b0);
        push_item(REQ_FLUSH, 3'd7, 16'hFFFF, 1'b0);
        push_item(REQ_FLUSH, 3'd2, 16'h8000, 1'b1);
        settle();

        // Channel count above the store size, zero bucket size
        set_config(4'd15, 24'd0);
        push_item(REQ_SAMPLE, 3'd0, 16'h8000, 1'b0);
        push_item(REQ_SAMPLE, 3'd1, 16'h7FFF, 1'b0);
        push_item(REQ_SAMPLE, 3'd2, 16'h5555, 1'b0);
        push_item(REQ_SAMPLE, 3'd3, 16'hAAAA, 1'b0);
        push_item(REQ_SAMPLE, 3'd4, 16'h0001, 1'b0);
        push_item(REQ_SAMPLE, 3'd5, 16'hFFFE, 1'b0);
        push_item(REQ_SAMPLE, 3'd6, 16'h0000, 1'b0);
        push_item(REQ_SAMPLE, 3'd7, 16'hFFFF, 1'b1);
        settle();

        // No channel tracked: a bucket end emits nothing
        set_config(4'd0, 24'd1);
        push_item(REQ_SAMPLE, 3'd0, 16'h7FFF, 1'b1);
        settle();

        // Largest bucket, then lower it below the frame count
        set_config(4'd2, 24'hFFFFFF);
        push_item(REQ_SAMPLE, 3'd0, 16'h1000, 1'b1);
        push_item(REQ_SAMPLE, 3'd1, 16'hF000, 1'b1);
        push_item(REQ_SAMPLE, 3'd0, 16'h8001, 1'b1);
        settle();
        set_config(4'd2, 24'd2);
        push_item(REQ_SAMPLE, 3'd1, 16'h7FFE, 1'b1);

        // Random phases, each under a fresh setting
        first_random = items_sent;
        while (items_sent - first_random < RANDOM_ITEMS) begin
            settle();
            pick_config();
            run_traffic(PHASE_ITEMS);
        end

        // Long receiver hold-off while full frames keep coming
        settle();
        set_config(CC_W'(MAX_CHANNELS), 24'd1);
        hold_off_req++;
        run_traffic(4 * MAX_CHANNELS);

        // Closing phase without idling on either side
        settle();
        quiet_tail = 1'b1;
        pick_config();
        run_traffic(PHASE_ITEMS);

        // Drain and give the verdict
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
